>>> rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants for the run-length block decoder
// Command beat passed from the front (framing) to the back (decode) and the
// counter saturation helper used on both sides.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH        = 2;
   localparam int unsigned HDR_SHIFT          = 8;
   localparam logic [7:0]  RUN_MASK           = 8'd127;
   localparam logic [15:0] OUT_LENGTH_RESET   = 16'd768;

   typedef enum logic {
      CMD_HEADER,
      CMD_BODY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } cmd_type;

   // clamp a value to the largest count that fits in bits
   function automatic logic [31:0] sat_count(input logic [31:0] v, input int unsigned bits);
      logic [63:0] max_wide;
      logic [31:0] max_val;
      max_wide = (64'd1 << bits) - 64'd1;
      max_val  = max_wide[31:0];
      return (v > max_val) ? max_val : v;
   endfunction

endpackage

>>> rtl/rbd_if.sv
// ----------------------------------------------------------------------------
// rbd_if: valid/ready channels of the run-length block decoder
// Request channel carries one compressed byte, response channel one run.
// ----------------------------------------------------------------------------
interface rbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface rbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value;
   logic [6:0] run;
   logic       decode_done;
   logic       block_end;

   modport source (output valid, output value, output run, output decode_done,
                   output block_end, input ready);
   modport sink   (input valid, input value, input run, input decode_done,
                   input block_end, output ready);
endinterface

>>> rtl/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front: block framing
// Parses the little-endian body length, counts body bytes and tags each beat
// as header or body, marking the last byte of the body.
// ----------------------------------------------------------------------------
module rbd_front #(
   parameter int unsigned COUNT_BITS = rbd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   rbd_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             q_push,
   output rbd_pkg::cmd_type q_cmd
);
   import rbd_pkg::*;

   typedef enum logic [1:0] {
      F_HDR_LO,
      F_HDR_HI,
      F_BODY
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [7:0]            len_lo_ff, len_lo_in;
   logic [COUNT_BITS-1:0] body_left_ff, body_left_in;
   logic [31:0]           len_sat;
   logic [COUNT_BITS-1:0] body_len;
   logic                  accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   assign len_sat  = sat_count(32'({req_chan.in_byte, len_lo_ff}), COUNT_BITS);
   assign body_len = len_sat[COUNT_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      len_lo_in    = len_lo_ff;
      body_left_in = body_left_ff;
      q_push       = 1'b0;
      q_cmd.kind   = CMD_BODY;
      q_cmd.data   = req_chan.in_byte;
      q_cmd.last   = 1'b0;
      if (accept) begin
         unique case (state_ff)
            F_HDR_LO: begin
               len_lo_in = req_chan.in_byte;
               state_in  = F_HDR_HI;
            end
            F_HDR_HI: begin
               q_push       = 1'b1;
               q_cmd.kind   = CMD_HEADER;
               q_cmd.last   = (body_len == '0);
               body_left_in = body_len;
               state_in     = (body_len == '0) ? F_HDR_LO : F_BODY;
            end
            F_BODY: begin
               q_push     = 1'b1;
               q_cmd.last = (body_left_ff <= COUNT_BITS'(1));
               if (body_left_ff != '0) begin
                  body_left_in = body_left_ff - COUNT_BITS'(1);
               end
               if (body_left_ff <= COUNT_BITS'(1)) begin
                  state_in = F_HDR_LO;
               end
            end
            default: begin
               state_in = F_HDR_LO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_HDR_LO;
         body_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         body_left_ff <= body_left_in;
      end
      len_lo_ff <= len_lo_in;
   end

endmodule

>>> rtl/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue: command queue
// Small first-in first-out buffer between framing and decode.
// ----------------------------------------------------------------------------
module rbd_queue #(
   parameter int unsigned DEPTH = rbd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output rbd_pkg::cmd_type head_cmd
);
   import rbd_pkg::*;

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   cmd_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/rbd_back.sv
// ----------------------------------------------------------------------------
// rbd_back: run decoder
// Executes control, repeat and literal bytes, clips runs to the output
// length and holds the response beat in an output register.
// ----------------------------------------------------------------------------
module rbd_back #(
   parameter int unsigned COUNT_BITS = rbd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      out_length,
   input  logic             q_not_empty,
   input  rbd_pkg::cmd_type q_head,
   output logic             q_pop,
   rbd_rsp_if.source        rsp_chan
);
   import rbd_pkg::*;

   typedef enum logic [1:0] {
      B_CTRL,
      B_REPEAT,
      B_LITERAL,
      B_SKIP
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] produced_ff, produced_in;
   logic [6:0]            literal_left_ff, literal_left_in;
   logic [6:0]            repeat_count_ff, repeat_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            value_ff, value_in;
   logic [6:0]            run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  end_ff, end_in;

   logic [31:0]           olen_sat;
   logic [COUNT_BITS-1:0] olen;
   logic [COUNT_BITS-1:0] rem;
   logic [COUNT_BITS-1:0] prod_sum;
   logic [6:0]            lit_next;
   logic                  advance;
   logic                  emit;

   assign olen_sat = sat_count(32'(out_length), COUNT_BITS);
   assign olen     = olen_sat[COUNT_BITS-1:0];
   assign rem      = (produced_ff < olen) ? (olen - produced_ff) : '0;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop   = q_not_empty && advance;

   always_comb begin
      state_in        = state_ff;
      produced_in     = produced_ff;
      literal_left_in = literal_left_ff;
      repeat_count_in = repeat_count_ff;
      value_in        = 8'd0;
      run_in          = 7'd0;
      done_in         = 1'b0;
      end_in          = 1'b0;
      prod_sum        = produced_ff;
      lit_next        = literal_left_ff;
      unique case (q_head.kind)
         CMD_HEADER: begin
            produced_in     = '0;
            literal_left_in = '0;
            repeat_count_in = '0;
            if (olen == '0) begin
               done_in  = 1'b1;
               state_in = B_SKIP;
            end else begin
               state_in = B_CTRL;
            end
         end
         CMD_BODY: begin
            unique case (state_ff)
               B_CTRL: begin
                  if (rem == '0 || q_head.data == 8'd0) begin
                     done_in = 1'b1;
                  end else if (q_head.data > RUN_MASK) begin
                     repeat_count_in = q_head.data[6:0];
                     state_in        = B_REPEAT;
                  end else begin
                     literal_left_in = q_head.data[6:0];
                     state_in        = B_LITERAL;
                  end
               end
               B_REPEAT: begin
                  // rem is below 128 whenever it is the smaller one
                  if (COUNT_BITS'(repeat_count_ff) < rem) begin
                     run_in = repeat_count_ff;
                  end else begin
                     run_in = rem[6:0];
                  end
                  if (run_in != 7'd0) begin
                     value_in = q_head.data;
                  end
                  prod_sum        = produced_ff + COUNT_BITS'(run_in);
                  produced_in     = prod_sum;
                  repeat_count_in = '0;
                  state_in        = B_CTRL;
                  if (prod_sum >= olen) begin
                     done_in = 1'b1;
                  end
               end
               B_LITERAL: begin
                  if (rem != '0) begin
                     value_in = q_head.data;
                     run_in   = 7'd1;
                     prod_sum = produced_ff + COUNT_BITS'(1);
                  end
                  produced_in = prod_sum;
                  if (literal_left_ff != '0) begin
                     lit_next = literal_left_ff - 7'd1;
                  end
                  literal_left_in = lit_next;
                  if (prod_sum >= olen) begin
                     done_in = 1'b1;
                  end else if (lit_next == '0) begin
                     state_in = B_CTRL;
                  end
               end
               B_SKIP: begin
                  state_in = B_SKIP;
               end
               default: begin
                  state_in = B_SKIP;
               end
            endcase
            if (done_in) begin
               state_in        = B_SKIP;
               literal_left_in = '0;
               repeat_count_in = '0;
            end
         end
         default: begin
            state_in = B_SKIP;
         end
      endcase
      // end of body: start the next block clean
      if (q_head.last) begin
         end_in          = 1'b1;
         state_in        = B_CTRL;
         produced_in     = '0;
         literal_left_in = '0;
         repeat_count_in = '0;
      end
   end

   assign emit = (run_in != 7'd0) || done_in || end_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= B_CTRL;
         produced_ff     <= '0;
         literal_left_ff <= '0;
         repeat_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            state_ff        <= state_in;
            produced_ff     <= produced_in;
            literal_left_ff <= literal_left_in;
            repeat_count_ff <= repeat_count_in;
         end
      end
      if (q_pop && emit) begin
         value_ff <= value_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value       = value_ff;
   assign rsp_chan.run         = run_ff;
   assign rsp_chan.decode_done = done_ff;
   assign rsp_chan.block_end   = end_ff;

endmodule

>>> rtl/rle_block_decoder.sv
// ----------------------------------------------------------------------------
// rle_block_decoder: byte-serial run-length block decoder
// Takes a compressed byte stream and returns one run descriptor per byte
// that writes output, stops decoding or ends a block.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one stream byte per beat: two length bytes (low first)
//   open each block, then the body. rsp_chan returns value/run pairs with
//   decode_done on the byte that stopped decoding and block_end on the last
//   body byte. Bytes that cause no response (length low byte, control
//   bytes, skipped body bytes) are taken silently.
//   csr_wr_en/csr_wr_data set the wanted output length per block; write it
//   only while the decoder is idle.
// Timing:
//   one byte per cycle sustained while responses are taken. An accepted byte
//   is written into the command queue; the decoder pops it and registers
//   its response in the output register, from which rsp_chan offers it.
// Stall:
//   a held response stops the decoder; the two-entry queue then fills and
//   req_chan.ready drops. Nothing is lost or repeated.
// Reset:
//   synchronous; the output length returns to 768 and the decoder waits
//   for a block length low byte.
// ----------------------------------------------------------------------------
module rle_block_decoder #(
   parameter int unsigned COUNT_BITS = rbd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rbd_req_if.sink     req_chan,
   rbd_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import rbd_pkg::*;

   logic [15:0] out_length_ff, out_length_in;
   logic        q_push, q_pop, q_full, q_not_empty;
   cmd_type     q_cmd, q_head;

   assign out_length_in = csr_wr_en ? csr_wr_data : out_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= OUT_LENGTH_RESET;
      end else begin
         out_length_ff <= out_length_in;
      end
   end

   rbd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   rbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   rbd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .out_length  (out_length_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_chan    (rsp_chan)
   );

   // a beat always carries data or status
   a_rsp_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.run != 7'd0 || rsp_chan.decode_done ||
                          rsp_chan.block_end))
      else $error("empty response beat");

   a_status_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.run == 7'd0) |-> (rsp_chan.value == 8'd0))
      else $error("status beat with nonzero value");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty command queue");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the run-length block decoder
// Feeds length-framed blocks of repeat, literal and stop codes through the
// request channel under random bursts and response stalls. A scoreboard
// decodes each accepted byte on its own and checks every response beat in
// order. The output length is changed between blocks, and once mid-block,
// while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
   import rbd_pkg::*;

   localparam logic [7:0] REPEAT_FLAG = 8'h80;
   localparam logic [7:0] STOP_CODE   = 8'h00;
   localparam int         DRAIN_WAIT  = 8;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] value;
      logic [6:0] run;
      logic       decode_done;
      logic       block_end;
   } run_beat_type;

   typedef enum logic [2:0] {
      LEN_LOW,
      LEN_HIGH,
      CONTROL,
      REPEAT_VALUE,
      LITERAL,
      SKIP
   } decode_phase_type;

   class rle_scoreboard;
      logic [15:0]      out_length;
      decode_phase_type phase;
      logic [15:0]      body_left;
      logic [15:0]      produced;
      logic [6:0]       literal_left;
      logic [6:0]       repeat_count;
      run_beat_type     pending_runs[$];
      int               mismatches;

      function new();
         out_length = OUT_LENGTH_RESET;
         mismatches = 0;
         clear_block();
      endfunction

      function void clear_block();
         phase        = LEN_LOW;
         body_left    = '0;
         produced     = '0;
         literal_left = '0;
         repeat_count = '0;
      endfunction

      function void set_out_length(input logic [15:0] v);
         out_length = v;
      endfunction

      // decode one accepted stream byte, queue the run it produces if any
      function void decode_byte(input logic [7:0] b);
         run_beat_type res;
         logic [15:0]  rem;
         res = '0;
         if (phase == LEN_LOW) begin
            body_left = {8'h00, b};
            phase     = LEN_HIGH;
            return;
         end
         if (phase == LEN_HIGH) begin
            body_left    = {b, body_left[7:0]};
            produced     = '0;
            literal_left = '0;
            repeat_count = '0;
            phase        = CONTROL;
            if (out_length == 0) begin
               res.decode_done = 1'b1;
               phase           = SKIP;
            end
         end else begin
            if (body_left != 0) body_left--;
            rem = (produced < out_length) ? out_length - produced : 16'd0;
            case (phase)
               CONTROL: begin
                  if (rem == 0 || b == STOP_CODE) begin
                     res.decode_done = 1'b1;
                  end else if (b[7]) begin
                     repeat_count = b[6:0];
                     phase        = REPEAT_VALUE;
                  end else begin
                     literal_left = b[6:0];
                     phase        = LITERAL;
                  end
               end
               REPEAT_VALUE: begin
                  res.run = ({9'd0, repeat_count} < rem) ? repeat_count : rem[6:0];
                  if (res.run != 0) res.value = b;
                  produced     = produced + {9'd0, res.run};
                  repeat_count = '0;
                  phase        = CONTROL;
                  if (produced >= out_length) res.decode_done = 1'b1;
               end
               LITERAL: begin
                  if (rem != 0) begin
                     res.value = b;
                     res.run   = 7'd1;
                     produced++;
                  end
                  if (literal_left != 0) literal_left--;
                  if (produced >= out_length) res.decode_done = 1'b1;
                  else if (literal_left == 0) phase = CONTROL;
               end
               default: ;
            endcase
            if (res.decode_done) begin
               phase        = SKIP;
               literal_left = '0;
               repeat_count = '0;
            end
         end
         if (body_left == 0) begin
            res.block_end = 1'b1;
            clear_block();
         end
         if (res.run != 0 || res.decode_done || res.block_end) pending_runs.push_back(res);
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_run(input run_beat_type got);
         run_beat_type want;
         if (pending_runs.size() == 0) begin
            report($sformatf("unexpected beat value %0d run %0d done %0b end %0b",
                             got.value, got.run, got.decode_done, got.block_end));
            return;
         end
         want = pending_runs.pop_front();
         if (got.value != want.value)
            report($sformatf("value %0d, want %0d", got.value, want.value));
         if (got.run != want.run)
            report($sformatf("run %0d, want %0d", got.run, want.run));
         if (got.decode_done != want.decode_done)
            report($sformatf("decode_done %0b, want %0b", got.decode_done, want.decode_done));
         if (got.block_end != want.block_end)
            report($sformatf("block_end %0b, want %0b", got.block_end, want.block_end));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   rbd_req_if req_chan ();
   rbd_rsp_if rsp_chan ();

   rle_block_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rle_scoreboard sb;
   int            burst_left;
   int            bytes_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   // one stream byte per beat, in bursts with random gaps between them
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sb.decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_all(input byte_q_type bytes);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // hold off until every run has come back, then let the pipeline settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_out_length(input logic [15:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_out_length(v);
   endtask

   // response side: the stall pattern switches to a random mode at the end of each random span
   initial begin
      int           mode;
      int           span;
      logic         rdy;
      run_beat_type got;
      rsp_chan.ready <= 1'b0;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.value       = rsp_chan.value;
            got.run         = rsp_chan.run;
            got.decode_done = rsp_chan.decode_done;
            got.block_end   = rsp_chan.block_end;
            sb.check_run(got);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
         end
         span--;
         case (mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 3) != 0);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ((span % 7) < 4);
         endcase
         rsp_chan.ready <= rdy;
      end
   end

   initial begin
      byte_q_type  stream;
      logic [15:0] len;
      int          random_start;
      int          n_ops;
      int          kind;
      int          cnt;

      sb = new();
      burst_left = 0;
      bytes_sent = 0;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // repeat 3 of 255, two literals, repeat of zero count, stop, skipped tail
      stream = '{8'h0A, 8'h00, REPEAT_FLAG | 8'd3, 8'hFF, 8'h02, 8'h00, 8'h80,
                 REPEAT_FLAG, 8'h55, STOP_CODE, 8'h7F, 8'hFF};
      send_all(stream);
      // empty body, then a repeat whose value byte falls past the body
      stream = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};
      send_all(stream);
      // zero output length: whole block skipped, with and without a body
      write_out_length(16'd0);
      stream = '{8'h02, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00};
      send_all(stream);
      // long repeat clipped to the output length
      write_out_length(16'd2);
      stream = '{8'h03, 8'h00, REPEAT_FLAG | 8'd127, 8'h11, 8'h42};
      send_all(stream);
      // length lowered below what the block already produced
      write_out_length(16'hFFFF);
      stream = '{8'h04, 8'h00, 8'h05, 8'h01, 8'h02};
      send_all(stream);
      write_out_length(16'd1);
      stream = '{8'h03};
      send_all(stream);

      random_start = bytes_sent;
      while (bytes_sent - random_start < 1000) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 7))
               0: write_out_length(16'd0);
               1: write_out_length(16'hFFFF);
               2: write_out_length(OUT_LENGTH_RESET);
               3: write_out_length(16'($urandom_range(1, 4)));
               4, 5: write_out_length(16'($urandom_range(1, 60)));
               6: write_out_length(16'($urandom_range(60, 400)));
               default: write_out_length(16'($urandom));
            endcase
         end
         stream.delete();
         if ($urandom_range(0, 9) == 0) begin
            // noise body
            repeat ($urandom_range(0, 24)) stream.push_back(8'($urandom));
         end else begin
            n_ops = $urandom_range(1, 6);
            repeat (n_ops) begin
               kind = $urandom_range(0, 9);
               if (kind < 4) begin
                  cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(1, 12);
                  stream.push_back(REPEAT_FLAG | 8'(cnt));
                  stream.push_back(8'($urandom));
               end else if (kind < 9) begin
                  cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
                                                   : $urandom_range(1, 6);
                  stream.push_back(8'(cnt));
                  repeat (cnt) stream.push_back(8'($urandom));
               end else begin
                  stream.push_back(STOP_CODE);
               end
            end
         end
         len = 16'(stream.size());
         case ($urandom_range(0, 9))
            0: begin
               // body shorter than its content
               len = 16'($urandom_range(0, len));
               while (stream.size() > len) void'(stream.pop_back());
            end
            1: begin
               // trailing junk inside the body
               repeat ($urandom_range(1, 5)) stream.push_back(8'($urandom));
               len = 16'(stream.size());
            end
            default: ;
         endcase
         stream.push_front(len[15:8]);
         stream.push_front(len[7:0]);
         send_all(stream);
      end

      drain();
      if (sb.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/rbd_pkg.sv
rtl/rbd_if.sv
rtl/rbd_front.sv
rtl/rbd_queue.sv
rtl/rbd_back.sv
rtl/rle_block_decoder.sv
tb/tb_top.sv
